>>> src/mtsfa_pkg.sv
// Package for the multitouch slot frame assembler.
// Holds the event codes, field widths and slot row layout.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package mtsfa_pkg;

	// Field widths of the event and result items.
	localparam int TYPE_W = 5;
	localparam int CODE_W = 10;
	localparam int VAL_W  = 32;

	// Default slot count.
	localparam int NUM_SLOTS_DEF = 16;

	// Event types and codes.
	localparam logic [TYPE_W-1:0] EV_SYN = TYPE_W'(0);
	localparam logic [TYPE_W-1:0] EV_ABS = TYPE_W'(3);

	localparam logic [CODE_W-1:0] CODE_REPORT   = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_DROPPED  = CODE_W'(3);
	localparam logic [CODE_W-1:0] CODE_SLOT     = CODE_W'('h2f);
	localparam logic [CODE_W-1:0] CODE_MAJOR    = CODE_W'('h30);
	localparam logic [CODE_W-1:0] CODE_POS_X    = CODE_W'('h35);
	localparam logic [CODE_W-1:0] CODE_POS_Y    = CODE_W'('h36);
	localparam logic [CODE_W-1:0] CODE_TRACK_ID = CODE_W'('h39);
	localparam logic [CODE_W-1:0] CODE_PRESSURE = CODE_W'('h3a);

	// Value of a field that was never set or a slot that is not in use.
	localparam logic [VAL_W-1:0] ABSENT = '1;

	// One slot row holds five 32-bit fields, one per lane.
	localparam int NUM_LANES = 5;
	localparam int LANE_W    = 3;

	typedef enum logic [LANE_W-1:0] {
		LANE_TID   = 3'd0,
		LANE_X     = 3'd1,
		LANE_Y     = 3'd2,
		LANE_PRESS = 3'd3,
		LANE_MAJOR = 3'd4
	} lane_t;

	typedef logic [NUM_LANES-1:0][VAL_W-1:0] row_t;

endpackage

`default_nettype wire

>>> src/multitouch_slot_frame_assembler_core.sv
// Multitouch slot frame assembler: slot protocol B event tracker.
// An event item is taken whenever the block is idle. After a report-sync is accepted,
// the scan steps past inactive slots and reads each active slot row into the read
// register, then into the output register; an empty frame gives one marker item.
// A slot read issues only when no earlier read waits in the read register and the
// output register is free or being taken; input is stalled for the whole scan.
// Reset: row valid and active bits clear at once, so no clearing pass is needed.
`default_nettype none

module multitouch_slot_frame_assembler_core #(
	parameter int NUM_SLOTS = mtsfa_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Event channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [mtsfa_pkg::TYPE_W-1:0]  ev_type,
	input  wire logic [mtsfa_pkg::CODE_W-1:0]  ev_code,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] ev_value,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               finger_valid,
	output logic signed [mtsfa_pkg::VAL_W-1:0] tracking_id,
	output logic signed [mtsfa_pkg::VAL_W-1:0] pos_x,
	output logic signed [mtsfa_pkg::VAL_W-1:0] pos_y,
	output logic signed [mtsfa_pkg::VAL_W-1:0] pressure,
	output logic signed [mtsfa_pkg::VAL_W-1:0] major_axis,
	output logic                               last
);
	import mtsfa_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                 state_q;
	logic [SLOT_W-1:0]      current_slot_q;
	logic                   slot_none_q;
	logic                   dropping_q;
	logic [NUM_SLOTS-1:0]   row_valid_q;
	logic [NUM_SLOTS-1:0]   active_q;
	logic [SLOT_W-1:0]      idx_q;
	logic                   empty_q;
	logic                   valid_s1;
	logic                   last_s1;
	logic                   out_valid_q;

	// Slot memory and its registered read port.
	row_t                   mem [NUM_SLOTS];
	row_t                   rd_row_q;

	logic                   accept;
	logic                   is_drop;
	logic                   is_report;
	logic                   is_slot_sel;
	logic                   slot_in_range;
	logic                   lane_hit;
	lane_t                  lane;
	logic                   wr_en;
	logic [NUM_LANES-1:0]   wr_mask;
	row_t                   wr_data;
	logic                   issue_ok;
	logic                   rd_en;
	logic                   more_above;
	logic                   out_take;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;

	// Event decode.
	assign is_drop     = (ev_type == EV_SYN) && (ev_code == CODE_DROPPED);
	assign is_report   = (ev_type == EV_SYN) && (ev_code == CODE_REPORT);
	assign is_slot_sel = (ev_type == EV_ABS) && (ev_code == CODE_SLOT);
	// Negative values have the top bit set and so fail the unsigned compare.
	assign slot_in_range = ($unsigned(ev_value) < VAL_W'(NUM_SLOTS));

	always_comb begin
		lane_hit = 1'b1;
		lane     = LANE_TID;
		case (ev_code)
			CODE_TRACK_ID: lane = LANE_TID;
			CODE_POS_X:    lane = LANE_X;
			CODE_POS_Y:    lane = LANE_Y;
			CODE_PRESSURE: lane = LANE_PRESS;
			CODE_MAJOR:    lane = LANE_MAJOR;
			default:       lane_hit = 1'b0;
		endcase
	end

	// Axis write: a row not yet valid is written whole, absent in all other lanes.
	assign wr_en = accept && !is_drop && !dropping_q && (ev_type == EV_ABS)
		&& !slot_none_q && lane_hit;

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			wr_data[k] = (LANE_W'(k) == lane) ? ev_value : ABSENT;
		end
		if (row_valid_q[current_slot_q]) begin
			wr_mask = NUM_LANES'(1) << lane;
		end else begin
			wr_mask = '1;
		end
	end

	// Scan control: a read issues only when the output register will be free.
	assign issue_ok = (state_q == ST_SCAN) && !valid_s1 && (!out_valid_q || !out_stall);
	assign rd_en    = issue_ok && !empty_q && active_q[idx_q];

	always_comb begin
		more_above = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (SLOT_W'(i) > idx_q) begin
				more_above = more_above | active_q[i];
			end
		end
	end

	// Slot memory: one write port with lane enables, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				if (wr_mask[k]) begin
					mem[current_slot_q][k] <= wr_data[k];
				end
			end
		end
		if (rd_en) begin
			rd_row_q <= mem[idx_q];
		end
	end

	// Control state machine, tracker state and the registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			current_slot_q <= '0;
			slot_none_q    <= 1'b0;
			dropping_q     <= 1'b0;
			row_valid_q    <= '0;
			active_q       <= '0;
			idx_q          <= '0;
			empty_q        <= 1'b0;
			valid_s1       <= 1'b0;
			last_s1        <= 1'b0;
			out_valid_q    <= 1'b0;
			finger_valid   <= 1'b0;
			tracking_id    <= '0;
			pos_x          <= '0;
			pos_y          <= '0;
			pressure       <= '0;
			major_axis     <= '0;
			last           <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (rd_en) begin
				last_s1 <= !more_above;
			end

			// Output register: a slot row, or the empty frame marker.
			if (valid_s1) begin
				out_valid_q  <= 1'b1;
				finger_valid <= 1'b1;
				tracking_id  <= rd_row_q[LANE_TID];
				pos_x        <= rd_row_q[LANE_X];
				pos_y        <= rd_row_q[LANE_Y];
				pressure     <= rd_row_q[LANE_PRESS];
				major_axis   <= rd_row_q[LANE_MAJOR];
				last         <= last_s1;
			end else if (issue_ok && empty_q) begin
				out_valid_q  <= 1'b1;
				finger_valid <= 1'b0;
				tracking_id  <= '0;
				pos_x        <= '0;
				pos_y        <= '0;
				pressure     <= '0;
				major_axis   <= '0;
				last         <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_drop) begin
							row_valid_q    <= '0;
							active_q       <= '0;
							current_slot_q <= '0;
							slot_none_q    <= 1'b0;
							dropping_q     <= 1'b1;
						end else if (dropping_q) begin
							if (is_report) begin
								dropping_q <= 1'b0;
							end
						end else if (is_slot_sel) begin
							if (slot_in_range) begin
								current_slot_q <= ev_value[SLOT_W-1:0];
								slot_none_q    <= 1'b0;
							end else begin
								slot_none_q <= 1'b1;
							end
						end else if (is_report) begin
							state_q <= ST_SCAN;
							idx_q   <= '0;
							empty_q <= (active_q == '0);
						end else if (wr_en) begin
							row_valid_q[current_slot_q] <= 1'b1;
							if (lane == LANE_TID) begin
								active_q[current_slot_q] <= (ev_value != ABSENT);
							end
						end
					end
				end
				ST_SCAN: begin
					if (empty_q) begin
						if (issue_ok) begin
							state_q <= ST_IDLE;
						end
					end else if (!active_q[idx_q]) begin
						idx_q <= idx_q + SLOT_W'(1);
					end else if (issue_ok) begin
						if (more_above) begin
							idx_q <= idx_q + SLOT_W'(1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/mtsfa_checker.sv
// Port-level checker for the multitouch slot frame assembler.
// Depends on mtsfa_pkg; bound to the top level at the end of this file.
`default_nettype none

module mtsfa_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [mtsfa_pkg::TYPE_W-1:0]  ev_type,
	input  wire logic [mtsfa_pkg::CODE_W-1:0]  ev_code,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] ev_value,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic                          finger_valid,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] tracking_id,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] pos_x,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] pos_y,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] pressure,
	input  wire logic signed [mtsfa_pkg::VAL_W-1:0] major_axis,
	input  wire logic                          last
);
	import mtsfa_pkg::*;

	// A stalled event item holds its valid and its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(ev_type) && $stable(ev_code)
			&& $stable(ev_value))
		else $error("stalled event item changed");

	// A stalled result item holds its valid, finger_valid, last, tracking_id and pos_x.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tracking_id) && $stable(pos_x)
			&& $stable(last) && $stable(finger_valid))
		else $error("stalled result item changed");

	// The empty frame marker is always the final item of its frame.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finger_valid |-> last)
		else $error("empty frame marker without last");

	// The empty frame marker carries zero in every data field.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finger_valid |-> (tracking_id == 0) && (pos_x == 0)
			&& (pos_y == 0) && (pressure == 0) && (major_axis == 0))
		else $error("empty frame marker with nonzero data");

	// A finger result always comes from an active slot.
	a_finger_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finger_valid |-> (tracking_id != ABSENT))
		else $error("finger result from an inactive slot");

endmodule

bind multitouch_slot_frame_assembler_core mtsfa_checker u_mtsfa_checker (.*);

`default_nettype wire

>>> tb/multitouch_slot_frame_assembler_core_tb.sv
// Testbench for the multitouch slot frame assembler core.
// Holds a slot tracker predictor, an event driver and a result checker.
// Depends on mtsfa_pkg and multitouch_slot_frame_assembler_core.
`timescale 1ns / 1ps

module multitouch_slot_frame_assembler_core_tb;

	import mtsfa_pkg::*;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam int RANDOM_EVENTS = 120;

	// One finger result as the block should present it.
	typedef struct packed {
		logic             finger_valid;
		logic [VAL_W-1:0] tracking_id;
		logic [VAL_W-1:0] pos_x;
		logic [VAL_W-1:0] pos_y;
		logic [VAL_W-1:0] pressure;
		logic [VAL_W-1:0] major_axis;
		logic             last;
	} finger_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [TYPE_W-1:0]       ev_type;
	logic [CODE_W-1:0]       ev_code;
	logic signed [VAL_W-1:0] ev_value;
	logic                    out_valid;
	logic                    out_stall;
	logic                    finger_valid;
	logic signed [VAL_W-1:0] tracking_id;
	logic signed [VAL_W-1:0] pos_x;
	logic signed [VAL_W-1:0] pos_y;
	logic signed [VAL_W-1:0] pressure;
	logic signed [VAL_W-1:0] major_axis;
	logic                    last;

	// Tracker state mirrored by the predictor.
	row_t        slot_rows [SLOTS];
	int unsigned sel_slot;
	bit          sel_none;
	bit          dropping;

	finger_t fingers_due [$];
	bit      gaps_on;
	int      events_sent;
	int      frames_sent;
	int      fingers_checked;
	int      mismatch_count;

	multitouch_slot_frame_assembler_core #(
		.NUM_SLOTS(SLOTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ev_type     (ev_type),
		.ev_code     (ev_code),
		.ev_value    (ev_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.finger_valid(finger_valid),
		.tracking_id (tracking_id),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pressure    (pressure),
		.major_axis  (major_axis),
		.last        (last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// Every slot empty, slot 0 selected.
	function automatic void clear_slots();
		for (int i = 0; i < SLOTS; i++) begin
			slot_rows[i] = '1;
		end
		sel_slot = 0;
		sel_none = 1'b0;
	endfunction

	// Advances the tracker by one event and queues the finger results it causes.
	function automatic void track_event(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
			logic [VAL_W-1:0] v);
		finger_t f;
		int      final_slot;
		final_slot = -1;
		if (t == EV_SYN && c == CODE_DROPPED) begin
			clear_slots();
			dropping = 1'b1;
			return;
		end
		if (dropping) begin
			if (t == EV_SYN && c == CODE_REPORT) begin
				dropping = 1'b0;
			end
			return;
		end
		if (t == EV_ABS && c == CODE_SLOT) begin
			// Negative values read as huge unsigned numbers and so are out of range.
			if (v < SLOTS) begin
				sel_slot = v;
				sel_none = 1'b0;
			end else begin
				sel_none = 1'b1;
			end
			return;
		end
		if (t == EV_SYN && c == CODE_REPORT) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_rows[i][LANE_TID] != ABSENT) begin
					final_slot = i;
				end
			end
			if (final_slot < 0) begin
				f = '0;
				f.last = 1'b1;
				fingers_due.push_back(f);
				return;
			end
			for (int i = 0; i <= final_slot; i++) begin
				if (slot_rows[i][LANE_TID] != ABSENT) begin
					f.finger_valid = 1'b1;
					f.tracking_id  = slot_rows[i][LANE_TID];
					f.pos_x        = slot_rows[i][LANE_X];
					f.pos_y        = slot_rows[i][LANE_Y];
					f.pressure     = slot_rows[i][LANE_PRESS];
					f.major_axis   = slot_rows[i][LANE_MAJOR];
					f.last         = (i == final_slot);
					fingers_due.push_back(f);
				end
			end
			return;
		end
		if (t == EV_ABS && !sel_none) begin
			case (c)
				CODE_TRACK_ID: slot_rows[sel_slot][LANE_TID]   = v;
				CODE_POS_X:    slot_rows[sel_slot][LANE_X]     = v;
				CODE_POS_Y:    slot_rows[sel_slot][LANE_Y]     = v;
				CODE_PRESSURE: slot_rows[sel_slot][LANE_PRESS] = v;
				CODE_MAJOR:    slot_rows[sel_slot][LANE_MAJOR] = v;
				default: ;
			endcase
		end
	endfunction

	// Presents one event item, with a random gap ahead of it, and waits until it is taken.
	task automatic send_event(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
			logic [VAL_W-1:0] v);
		while (gaps_on && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ev_type  <= t;
		ev_code  <= c;
		ev_value <= v;
		do begin
			@(posedge clk);
		end while (!(in_valid && !in_stall));
		track_event(t, c, v);
		events_sent++;
		if (t == EV_SYN && c == CODE_REPORT) begin
			frames_sent++;
		end
	endtask

	// Axis value with weight on the extremes and on small numbers.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3, 4: return $urandom_range(0, 4095);
			default: return $urandom();
		endcase
	endfunction

	// Tracking id: mostly a live contact, sometimes a lift.
	function automatic logic [VAL_W-1:0] pick_tracking_id();
		logic [VAL_W-1:0] id;
		id = $urandom();
		if (id == ABSENT) begin
			id = '0;
		end
		return ($urandom_range(99) < 12) ? ABSENT : id;
	endfunction

	// Slot number: mostly in range, sometimes above the top or negative.
	function automatic logic [VAL_W-1:0] pick_slot();
		case ($urandom_range(0, 19))
			0: return SLOTS + $urandom_range(0, 100);
			1: return $urandom() | 32'h8000_0000;
			default: return $urandom_range(0, SLOTS - 1);
		endcase
	endfunction

	// Compares one field of a result and reports a mismatch.
	function automatic void check_field(string field, logic [VAL_W-1:0] want,
			logic [VAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	// Result checker against the oldest expected finger.
	always @(posedge clk) begin : check_results
		finger_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (fingers_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tracking id %h",
					$time, tracking_id);
				mismatch_count++;
			end else begin
				want = fingers_due.pop_front();
				check_field("finger_valid", want.finger_valid, finger_valid);
				check_field("tracking_id", want.tracking_id, tracking_id);
				check_field("pos_x", want.pos_x, pos_x);
				check_field("pos_y", want.pos_y, pos_y);
				check_field("pressure", want.pressure, pressure);
				check_field("major_axis", want.major_axis, major_axis);
				check_field("last", want.last, last);
				fingers_checked++;
			end
		end
	end

	// Random back pressure on the result channel.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= gaps_on && ($urandom_range(99) < 6);
		end
	end

	// Fills one slot: the given id, the value in X and pressure, its inverse in Y and major axis.
	task automatic fill_slot(logic [VAL_W-1:0] s, logic [VAL_W-1:0] id, logic [VAL_W-1:0] v);
		send_event(EV_ABS, CODE_SLOT, s);
		send_event(EV_ABS, CODE_TRACK_ID, id);
		send_event(EV_ABS, CODE_POS_X, v);
		send_event(EV_ABS, CODE_POS_Y, ~v);
		send_event(EV_ABS, CODE_PRESSURE, v);
		send_event(EV_ABS, CODE_MAJOR, ~v);
	endtask

	// An empty frame after reset, then the lowest and highest slots at value extremes.
	task automatic test_empty_and_extremes();
		send_event(EV_SYN, CODE_REPORT, '0);
		fill_slot(0, 32'h8000_0000, 32'h7fff_ffff);
		fill_slot(SLOTS - 1, 32'h7fff_ffff, 32'h0000_0000);
		send_event(EV_SYN, CODE_REPORT, '0);
	endtask

	// Out-of-range slots block data until a valid slot is picked again.
	task automatic test_slot_range();
		send_event(EV_ABS, CODE_SLOT, SLOTS);
		send_event(EV_ABS, CODE_POS_X, 32'h1234_5678);
		send_event(EV_ABS, CODE_SLOT, 32'hffff_ffff);
		send_event(EV_ABS, CODE_TRACK_ID, 32'h0000_0055);
		send_event(EV_ABS, CODE_SLOT, 3);
		send_event(EV_ABS, CODE_TRACK_ID, 32'h0000_0007);
		send_event(EV_SYN, CODE_REPORT, '0);
	endtask

	// Other types, other sync codes and other axis codes leave the slots alone.
	task automatic test_ignored_events();
		send_event(5'h1f, CODE_TRACK_ID, 32'h0000_0009);
		send_event(EV_SYN, 10'h3ff, 32'hffff_ffff);
		send_event(EV_ABS, 10'h031, 32'h5555_5555);
		send_event(EV_ABS, 10'h3ff, 32'haaaa_aaaa);
	endtask

	// Writing tracking id -1 lifts the finger but keeps the other fields.
	task automatic test_release();
		send_event(EV_ABS, CODE_SLOT, 0);
		send_event(EV_ABS, CODE_TRACK_ID, ABSENT);
		send_event(EV_SYN, CODE_REPORT, '0);
		send_event(EV_ABS, CODE_TRACK_ID, 32'h0000_0001);
		send_event(EV_SYN, CODE_REPORT, '0);
	endtask

	// Dropped sync clears everything, a second one keeps dropping, the report ends it.
	task automatic test_dropped_sync();
		send_event(EV_SYN, CODE_DROPPED, '0);
		send_event(EV_ABS, CODE_TRACK_ID, 32'h0000_0042);
		send_event(EV_SYN, CODE_DROPPED, 32'hffff_ffff);
		send_event(EV_SYN, CODE_REPORT, '0);
		send_event(EV_SYN, CODE_REPORT, '0);
	endtask

	// One well-formed frame with random content, now and then broken by noise or a drop.
	task automatic random_frame();
		int touches;
		touches = $urandom_range(1, 4);
		for (int k = 0; k < touches; k++) begin
			if (k > 0 || $urandom_range(99) < 85) begin
				send_event(EV_ABS, CODE_SLOT, pick_slot());
			end
			if ($urandom_range(1)) send_event(EV_ABS, CODE_TRACK_ID, pick_tracking_id());
			if ($urandom_range(1)) send_event(EV_ABS, CODE_POS_X, pick_value());
			if ($urandom_range(1)) send_event(EV_ABS, CODE_POS_Y, pick_value());
			if ($urandom_range(1)) send_event(EV_ABS, CODE_PRESSURE, pick_value());
			if ($urandom_range(1)) send_event(EV_ABS, CODE_MAJOR, pick_value());
			if ($urandom_range(99) < 10) begin
				send_event(TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 1023)),
					$urandom());
			end
		end
		if ($urandom_range(99) < 5) begin
			send_event(EV_SYN, CODE_DROPPED, $urandom());
			send_event(EV_ABS, CODE_TRACK_ID, pick_tracking_id());
		end
		send_event(EV_SYN, CODE_REPORT, $urandom());
	endtask

	// Random frames until the event budget is spent.
	task automatic test_random_frames();
		int stop_at;
		stop_at = events_sent + RANDOM_EVENTS;
		while (events_sent < stop_at) begin
			random_frame();
		end
	endtask

	// A stretch of frames with no gaps and no back pressure at all.
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		for (int k = 0; k < 6; k++) begin
			random_frame();
		end
		gaps_on = 1'b1;
	endtask

	// Main sequence.
	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		ev_type  <= '0;
		ev_code  <= '0;
		ev_value <= '0;
		gaps_on         = 1'b1;
		events_sent     = 0;
		frames_sent     = 0;
		fingers_checked = 0;
		mismatch_count  = 0;
		clear_slots();
		dropping = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_slot_range();
		test_ignored_events();
		test_release();
		test_dropped_sync();
		test_random_frames();
		test_back_to_back();
		in_valid <= 1'b0;

		// Drain the outstanding results, then allow one full slot scan more.
		while (fingers_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * SLOTS + 20) @(posedge clk);

		$display("summary: %0d events sent, %0d frames reported, %0d results checked",
			events_sent, frames_sent, fingers_checked);
		$display("summary: %0d mismatches", mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
